// ----- rtl/accel_tilt_angle_top_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the tilt angle block
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLE_TOP_ASSERT_SVH
`define ACCEL_TILT_ANGLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define ATILT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tilt angle assertion failed");

// Next-cycle implication.
`define ATILT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tilt angle assertion failed");

`endif

// ----- rtl/atilt_pkg.sv -----
// ---------------------------------------------------------------------------
// Tilt angle package
// Shared types, constants and arithmetic helpers of the tilt angle block.
// ---------------------------------------------------------------------------
package atilt_pkg;

  localparam int unsigned SAMPLE_W        = 12;
  localparam int unsigned DEV_W           = 13;
  localparam int unsigned ANGLE_W         = 9;
  localparam int unsigned SUM_W           = 15;
  localparam int unsigned CNT_W           = 3;
  localparam int unsigned SAMPLES_PER_SET = 5;

  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP       = (2 ** RECIP_SHIFT + SAMPLES_PER_SET - 1)
                                        / SAMPLES_PER_SET;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CORDIC_STEPS = 17;
  localparam int unsigned ITER_W       = $clog2(CORDIC_STEPS);
  localparam int unsigned OPER_W       = 32;
  localparam int unsigned ANG_W        = 20;
  localparam int unsigned FRAC_W       = 16;

  localparam logic signed [ANG_W-1:0] PI_FIX          = 20'sd205887;
  localparam logic signed [ANG_W-1:0] THREE_RAD_FIX   = 20'sd196608;
  localparam logic signed [ANG_W-1:0] MINUS_LIMIT_FIX = -20'sd98304;

  localparam logic [ANGLE_W-1:0] ANGLE_FULL = 9'd400;
  localparam int unsigned SCALE_W   = 27;
  localparam int unsigned THIRD_W   = 11;
  localparam int unsigned THIRD_MUL = 683;
  localparam int unsigned THIRD_SH  = 11;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2, 20'sd1
  };

  typedef enum logic [1:0] {
    REG_X_OFFSET = 2'd0,
    REG_Y_OFFSET = 2'd1,
    REG_Z_OFFSET = 2'd2,
    REG_SPARE    = 2'd3
  } reg_idx_e;

  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 12'd2000;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ITER   = 4'b0010,
    ST_SCALE  = 4'b0100,
    ST_FINISH = 4'b1000
  } back_state_e;

  typedef struct packed {
    logic [DEV_W-1:0] dx;
    logic [DEV_W-1:0] dy;
    logic [DEV_W-1:0] dz;
  } dev_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic valid;
  } queue_ctl_t;

  function automatic logic [SAMPLE_W-1:0] div_set(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(RECIP);
    return p[RECIP_SHIFT +: SAMPLE_W];
  endfunction

endpackage

// ----- rtl/accel_tilt_angle_top.sv -----
// ---------------------------------------------------------------------------
// Accelerometer tilt angle
// Averages sets of three-axis samples and gives the deviations and tilt angle.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o   sample_x_i, sample_y_i, sample_z_i
//  out      output     out_valid_o/out_stall_i tilt_angle_o, dev_x_o/_y_o/_z_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  The front end takes one sample a cycle while it is not stalling; after the
//  last sample of a set it stalls until the averages are formed and queued.
//  The back end works through one set at a time: a load, 17 vectoring steps,
//  a scale and a result step, and loads no new set until its result is registered.
//  Reset clears the sums and counters and sets every offset to 2000.
//  A two-entry queue lets either side stall without holding the other.
// ---------------------------------------------------------------------------
module accel_tilt_angle_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [atilt_pkg::SAMPLE_W-1:0] sample_x_i,
  input  logic [atilt_pkg::SAMPLE_W-1:0] sample_y_i,
  input  logic [atilt_pkg::SAMPLE_W-1:0] sample_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [atilt_pkg::ANGLE_W-1:0] tilt_angle_o,
  output logic [atilt_pkg::DEV_W-1:0]   dev_x_o,
  output logic [atilt_pkg::DEV_W-1:0]   dev_y_o,
  output logic [atilt_pkg::DEV_W-1:0]   dev_z_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [atilt_pkg::SAMPLE_W-1:0] cfg_data_i
);
  import atilt_pkg::*;

  queue_ctl_t q_ctl;
  dev_t       q_wr_data, q_rd_data;

  assign cfg_ready_o = 1'b1;

  atilt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .sample_z_i (sample_z_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_ctl.full),
    .q_push_o   (q_ctl.push),
    .q_data_o   (q_wr_data)
  );

  atilt_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (q_ctl),
    .wr_data_i(q_wr_data),
    .full_o   (q_ctl.full),
    .valid_o  (q_ctl.valid),
    .rd_data_o(q_rd_data)
  );

  atilt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_ctl.valid),
    .q_pop_o     (q_ctl.pop),
    .q_data_i    (q_rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tilt_angle_o(tilt_angle_o),
    .dev_x_o     (dev_x_o),
    .dev_y_o     (dev_y_o),
    .dev_z_o     (dev_z_o)
  );

endmodule

// ----- rtl/atilt_front.sv -----
// ---------------------------------------------------------------------------
// Tilt angle front end
// Accumulates a set of samples per axis, then averages and removes offsets.
// ---------------------------------------------------------------------------
module atilt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [atilt_pkg::SAMPLE_W-1:0] sample_x_i,
  input  logic [atilt_pkg::SAMPLE_W-1:0] sample_y_i,
  input  logic [atilt_pkg::SAMPLE_W-1:0] sample_z_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [atilt_pkg::SAMPLE_W-1:0] cfg_data_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output atilt_pkg::dev_t               q_data_o
);
  import atilt_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_SET - 1);

  logic [SUM_W-1:0]    sum_x_q, sum_y_q, sum_z_q;
  logic [SUM_W-1:0]    sum_x_d, sum_y_d, sum_z_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [SAMPLE_W-1:0] off_x_q, off_y_q, off_z_q;
  logic                accept;

  assign in_stall_o = pend_q;
  assign accept     = in_valid_i && !pend_q;
  assign q_push_o   = pend_q && !q_full_i;

  assign q_data_o.dx = {1'b0, div_set(sum_x_q)} - {1'b0, off_x_q};
  assign q_data_o.dy = {1'b0, div_set(sum_y_q)} - {1'b0, off_y_q};
  assign q_data_o.dz = {1'b0, div_set(sum_z_q)} - {1'b0, off_z_q};

  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    sum_z_d = sum_z_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    if (q_push_o) begin
      sum_x_d = '0;
      sum_y_d = '0;
      sum_z_d = '0;
      cnt_d   = '0;
      pend_d  = 1'b0;
    end else if (accept) begin
      sum_x_d = sum_x_q + SUM_W'(sample_x_i);
      sum_y_d = sum_y_q + SUM_W'(sample_y_i);
      sum_z_d = sum_z_q + SUM_W'(sample_z_i);
      if (cnt_q == LAST_CNT) begin
        pend_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= OFFSET_RESET;
      off_y_q <= OFFSET_RESET;
      off_z_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_X_OFFSET: off_x_q <= cfg_data_i;
        REG_Y_OFFSET: off_y_q <= cfg_data_i;
        REG_Z_OFFSET: off_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/atilt_fifo.sv -----
// ---------------------------------------------------------------------------
// Tilt angle deviation queue
// Short first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
module atilt_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atilt_pkg::queue_ctl_t ctl_i,
  input  atilt_pkg::dev_t      wr_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  output atilt_pkg::dev_t      rd_data_o
);
  import atilt_pkg::*;

  dev_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (ctl_i.push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (ctl_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (ctl_i.push && !ctl_i.pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!ctl_i.push && ctl_i.pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/atilt_back.sv -----
// ---------------------------------------------------------------------------
// Tilt angle back end
// Iterative vectoring unit for the angle, clamping, scaling and result register.
// ---------------------------------------------------------------------------
module atilt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  atilt_pkg::dev_t               q_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [atilt_pkg::ANGLE_W-1:0] tilt_angle_o,
  output logic [atilt_pkg::DEV_W-1:0]   dev_x_o,
  output logic [atilt_pkg::DEV_W-1:0]   dev_y_o,
  output logic [atilt_pkg::DEV_W-1:0]   dev_z_o
);
  import atilt_pkg::*;

  back_state_e              state_q, state_d;
  logic [ITER_W-1:0]        iter_q;
  logic signed [OPER_W-1:0] x_q, z_q, x_d, z_d, xs, zs, x_init, z_init;
  logic signed [ANG_W-1:0]  ang_q, ang_d, ang_init;
  dev_t                     dev_q;
  logic                     zero_q;
  logic                     sel_max_q, sel_zero_q;
  logic [SCALE_W-1:0]       prod_q;
  logic [THIRD_W-1:0]       whole;
  logic [THIRD_W+9:0]       third_prod;
  logic [ANGLE_W-1:0]       angle;
  logic                     out_valid_q;
  logic                     slot_free;
  logic                     load_out;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign q_pop_o   = (state_q == ST_IDLE) && q_valid_i;
  assign load_out  = (state_q == ST_FINISH) && slot_free;

  assign x_init = {{3{q_data_i.dx[DEV_W-1]}}, q_data_i.dx, {FRAC_W{1'b0}}};
  assign z_init = {{3{q_data_i.dz[DEV_W-1]}}, q_data_i.dz, {FRAC_W{1'b0}}};
  assign ang_init = q_data_i.dx[DEV_W-1] ?
                    (q_data_i.dz[DEV_W-1] ? -PI_FIX : PI_FIX) : '0;

  assign xs = x_q >>> iter_q;
  assign zs = z_q >>> iter_q;

  always_comb begin
    if (!z_q[OPER_W-1]) begin
      x_d   = x_q + zs;
      z_d   = z_q - xs;
      ang_d = ang_q + ATAN_TAB[iter_q];
    end else begin
      x_d   = x_q - zs;
      z_d   = z_q + xs;
      ang_d = ang_q - ATAN_TAB[iter_q];
    end
  end

  assign whole      = prod_q[FRAC_W +: THIRD_W];
  assign third_prod = (THIRD_W + 10)'(whole) * (THIRD_W + 10)'(THIRD_MUL);
  assign angle      = sel_max_q  ? ANGLE_FULL :
                      sel_zero_q ? '0 : third_prod[THIRD_SH +: ANGLE_W];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (q_valid_i) state_d = ST_ITER;
      ST_ITER:   if (iter_q == ITER_W'(CORDIC_STEPS - 1)) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_FINISH;
      ST_FINISH: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        iter_q <= '0;
        x_q    <= q_data_i.dx[DEV_W-1] ? -x_init : x_init;
        z_q    <= q_data_i.dx[DEV_W-1] ? -z_init : z_init;
        ang_q  <= ang_init;
        dev_q  <= q_data_i;
        zero_q <= (q_data_i.dx == '0) && (q_data_i.dz == '0);
      end
      ST_ITER: begin
        iter_q <= iter_q + 1'b1;
        x_q    <= x_d;
        z_q    <= z_d;
        ang_q  <= ang_d;
      end
      ST_SCALE: begin
        sel_max_q  <= !zero_q && ((ang_q > THREE_RAD_FIX) || (ang_q < MINUS_LIMIT_FIX));
        sel_zero_q <= zero_q || ang_q[ANG_W-1];
        prod_q     <= SCALE_W'(ang_q[17:0]) * SCALE_W'(ANGLE_FULL);
      end
      ST_FINISH: begin
        if (slot_free) begin
          tilt_angle_o <= angle;
          dev_x_o      <= dev_q.dx;
          dev_y_o      <= dev_q.dy;
          dev_z_o      <= dev_q.dz;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/atilt_checker.sv -----
// ---------------------------------------------------------------------------
// Tilt angle port checker
// Watches the ports of the tilt angle block and is bound to its top level.
// ---------------------------------------------------------------------------
`include "accel_tilt_angle_top_assert.svh"

module atilt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [atilt_pkg::SAMPLE_W-1:0] sample_x_i,
  input logic [atilt_pkg::SAMPLE_W-1:0] sample_y_i,
  input logic [atilt_pkg::SAMPLE_W-1:0] sample_z_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [atilt_pkg::ANGLE_W-1:0] tilt_angle_o,
  input logic [atilt_pkg::DEV_W-1:0]   dev_x_o,
  input logic [atilt_pkg::DEV_W-1:0]   dev_y_o,
  input logic [atilt_pkg::DEV_W-1:0]   dev_z_o,
  input logic                          cfg_ready_o
);
  import atilt_pkg::*;

  logic [3*SAMPLE_W-1:0]      in_req;
  logic [ANGLE_W+3*DEV_W-1:0] out_req;

  assign in_req  = {sample_x_i, sample_y_i, sample_z_i};
  assign out_req = {tilt_angle_o, dev_x_o, dev_y_o, dev_z_o};

  `ATILT_ASSERT(a_angle_range, out_valid_o, tilt_angle_o <= ANGLE_FULL)
  `ATILT_ASSERT(a_flat_zero, out_valid_o && dev_x_o == '0 && dev_z_o == '0, tilt_angle_o == '0)
  `ATILT_ASSERT(a_cfg_ready, 1'b1, cfg_ready_o)
  `ATILT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_req))
  `ATILT_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_req))

endmodule

bind accel_tilt_angle_top atilt_checker u_atilt_checker (.*);

// ----- tb/accel_tilt_angle_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench of the accelerometer tilt angle block
// Feeds sets of three-axis samples through the request channel under random
// sender gaps and receiver stalls. The offsets are reprogrammed between
// phases. Results are checked field by field against a fixed-point
// vectoring predictor kept in step with the offsets, or against the wanted values of the directed rows.
// ---------------------------------------------------------------------------
module accel_tilt_angle_top_tb;
  import atilt_pkg::*;

  localparam int          SET_LEN         = 5;
  localparam int          VECTOR_STEPS    = 17;
  localparam longint      PI_Q16          = 205887;
  localparam longint      UPPER_CLAMP_Q16 = 196608;
  localparam longint      LOWER_CLAMP_Q16 = -98304;
  localparam int          SETTLE_CYCLES   = 40;
  localparam int          RAND_SETS       = 30;
  localparam logic [8:0]  ANGLE_TOP       = 9'd400;
  localparam longint ATAN_STEP [VECTOR_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1
  };

  typedef struct packed {
    logic [ANGLE_W-1:0]      angle;
    logic signed [DEV_W-1:0] dx;
    logic signed [DEV_W-1:0] dy;
    logic signed [DEV_W-1:0] dz;
  } tilt_res_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    logic [SAMPLE_W-1:0] xl;
    logic [SAMPLE_W-1:0] yl;
    logic [SAMPLE_W-1:0] zl;
    logic                typed;
    tilt_res_t           want;
  } dir_row_t;

  typedef enum int {
    SHAPE_SPREAD,
    SHAPE_AT_ZERO,
    SHAPE_NEAR_ZERO,
    SHAPE_RAIL
  } shape_e;

  localparam dir_row_t DIR_ROWS [5] = '{
    '{12'd2000, 12'd2000, 12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b1,
      '{9'd0, 13'sd0, 13'sd0, 13'sd0}},
    '{12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0, 1'b1,
      '{9'd0, 13'sd2095, -13'sd2000, -13'sd2000}},
    '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1,
      '{9'd400, -13'sd2000, -13'sd2000, -13'sd2000}},
    '{12'd0, 12'd4095, 12'd2001, 12'd0, 12'd4095, 12'd2001, 1'b1,
      '{9'd400, -13'sd2000, 13'sd2095, 13'sd1}},
    '{12'd2000, 12'd1, 12'd4095, 12'd2004, 12'd0, 12'd4091, 1'b0,
      '{9'd0, 13'sd0, 13'sd0, 13'sd0}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_x_i;
  logic [SAMPLE_W-1:0] sample_y_i;
  logic [SAMPLE_W-1:0] sample_z_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ANGLE_W-1:0]  tilt_angle_o;
  logic [DEV_W-1:0]    dev_x_o;
  logic [DEV_W-1:0]    dev_y_o;
  logic [DEV_W-1:0]    dev_z_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [SAMPLE_W-1:0] cfg_data_i;

  tilt_res_t           pending_results [$];
  logic [SAMPLE_W-1:0] offset_q [3];
  int unsigned         sum_x_q;
  int unsigned         sum_y_q;
  int unsigned         sum_z_q;
  int                  set_fill;
  int                  mismatch_cnt;
  int                  send_gap_pct;
  int                  recv_stall_pct;

  accel_tilt_angle_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_x_i   (sample_x_i),
    .sample_y_i   (sample_y_i),
    .sample_z_i   (sample_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tilt_angle_o (tilt_angle_o),
    .dev_x_o      (dev_x_o),
    .dev_y_o      (dev_y_o),
    .dev_z_o      (dev_z_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ANGLE_W-1:0] tilt_of(input int dx, input int dz);
    longint x;
    longint z;
    longint xs;
    longint zs;
    longint ang;
    longint q;
    int     i;
    if (dx == 0 && dz == 0) begin
      return '0;
    end
    x   = longint'(dx) * 65536;
    z   = longint'(dz) * 65536;
    ang = 0;
    if (dx < 0) begin
      x   = -x;
      z   = -z;
      ang = (dz >= 0) ? PI_Q16 : -PI_Q16;
    end
    for (i = 0; i < VECTOR_STEPS; i++) begin
      xs = x >>> i;
      zs = z >>> i;
      if (z >= 0) begin
        x   = x + zs;
        z   = z - xs;
        ang = ang + ATAN_STEP[i];
      end else begin
        x   = x - zs;
        z   = z + xs;
        ang = ang - ATAN_STEP[i];
      end
    end
    if (ang > UPPER_CLAMP_Q16 || ang < LOWER_CLAMP_Q16) begin
      return ANGLE_TOP;
    end
    if (ang < 0) begin
      return '0;
    end
    q = (ang * 400) / (3 * 65536);
    return q[ANGLE_W-1:0];
  endfunction

  // Adds one sample to the running sums and gives the averaged result once
  // the set is complete.
  function automatic bit absorb_sample(input logic [SAMPLE_W-1:0] x,
                                       input logic [SAMPLE_W-1:0] y,
                                       input logic [SAMPLE_W-1:0] z,
                                       output tilt_res_t r);
    int dx;
    int dy;
    int dz;
    r       = '0;
    sum_x_q = (sum_x_q + x) & 32'h7FFF;
    sum_y_q = (sum_y_q + y) & 32'h7FFF;
    sum_z_q = (sum_z_q + z) & 32'h7FFF;
    if (set_fill + 1 < SET_LEN) begin
      set_fill++;
      return 1'b0;
    end
    dx = int'(sum_x_q / SET_LEN) - int'(offset_q[0]);
    dy = int'(sum_y_q / SET_LEN) - int'(offset_q[1]);
    dz = int'(sum_z_q / SET_LEN) - int'(offset_q[2]);
    r.angle  = tilt_of(dx, dz);
    r.dx     = dx[DEV_W-1:0];
    r.dy     = dy[DEV_W-1:0];
    r.dz     = dz[DEV_W-1:0];
    sum_x_q  = 0;
    sum_y_q  = 0;
    sum_z_q  = 0;
    set_fill = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Entered just after a falling edge; returns just after a falling edge with
  // the request still raised, so the caller decides what follows.
  task automatic send_sample(input logic [SAMPLE_W-1:0] x,
                             input logic [SAMPLE_W-1:0] y,
                             input logic [SAMPLE_W-1:0] z,
                             input bit typed,
                             input tilt_res_t want);
    tilt_res_t r;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    sample_y_i <= y;
    sample_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    if (absorb_sample(x, y, z, r)) begin
      pending_results.push_back(typed ? want : r);
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [SAMPLE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_X_OFFSET: offset_q[0] = val;
      REG_Y_OFFSET: offset_q[1] = val;
      REG_Z_OFFSET: offset_q[2] = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_offsets(input int setting);
    logic [SAMPLE_W-1:0] v [3];
    foreach (v[a]) v[a] = SAMPLE_W'($urandom_range(0, 4095));
    case (setting)
      0: v = '{12'd0, 12'd0, 12'd0};
      1: v = '{12'd4095, 12'd4095, 12'd4095};
      3: begin
        v[0] = 12'd4095;
        v[2] = 12'd0;
      end
      4: begin
        v[0] = 12'd0;
        v[2] = 12'd4095;
      end
      default: ;
    endcase
    write_reg(REG_X_OFFSET, v[0]);
    write_reg(REG_Y_OFFSET, v[1]);
    write_reg(REG_Z_OFFSET, v[2]);
    write_reg(REG_SPARE, SAMPLE_W'($urandom_range(0, 4095)));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(input shape_e shape,
                                                      input int centre);
    int v;
    case (shape)
      SHAPE_SPREAD:    v = $urandom_range(0, 4095);
      SHAPE_NEAR_ZERO: v = centre + int'($urandom_range(0, 6)) - 3;
      default:         v = centre;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic send_random_sets(input int sets);
    shape_e              shape [3];
    int                  centre [3];
    int                  pick;
    logic [SAMPLE_W-1:0] s [3];
    repeat (sets) begin
      foreach (shape[a]) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          shape[a]  = SHAPE_SPREAD;
          centre[a] = 0;
        end else if (pick < 5) begin
          shape[a]  = SHAPE_AT_ZERO;
          centre[a] = offset_q[a];
        end else if (pick < 8) begin
          shape[a]  = SHAPE_NEAR_ZERO;
          centre[a] = int'(offset_q[a]) + int'($urandom_range(0, 40)) - 20;
        end else begin
          shape[a]  = SHAPE_RAIL;
          centre[a] = $urandom_range(0, 1) ? 4095 : 0;
        end
      end
      repeat (SET_LEN) begin
        foreach (s[a]) s[a] = draw_sample(shape[a], centre[a]);
        send_sample(s[0], s[1], s[2], 1'b0, '0);
      end
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    tilt_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, angle %0d", tilt_angle_o));
      end else begin
        want = pending_results.pop_front();
        if (tilt_angle_o !== want.angle)
          report_mismatch($sformatf("tilt_angle %0d, wanted %0d",
                                    tilt_angle_o, want.angle));
        if (dev_x_o !== want.dx)
          report_mismatch($sformatf("dev_x %0d, wanted %0d",
                                    $signed(dev_x_o), want.dx));
        if (dev_y_o !== want.dy)
          report_mismatch($sformatf("dev_y %0d, wanted %0d",
                                    $signed(dev_y_o), want.dy));
        if (dev_z_o !== want.dz)
          report_mismatch($sformatf("dev_z %0d, wanted %0d",
                                    $signed(dev_z_o), want.dz));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_x_i     = '0;
    sample_y_i     = '0;
    sample_z_i     = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_X_OFFSET;
    cfg_data_i     = '0;
    offset_q       = '{12'd2000, 12'd2000, 12'd2000};
    sum_x_q        = 0;
    sum_y_q        = 0;
    sum_z_q        = 0;
    set_fill       = 0;
    mismatch_cnt   = 0;
    send_gap_pct   = 15;
    recv_stall_pct = 72;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIR_ROWS[r]) begin
      repeat (SET_LEN - 1) begin
        send_sample(DIR_ROWS[r].x, DIR_ROWS[r].y, DIR_ROWS[r].z, 1'b0, '0);
      end
      send_sample(DIR_ROWS[r].xl, DIR_ROWS[r].yl, DIR_ROWS[r].zl,
                  DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    for (int m = 0; m < 3; m++) begin
      send_gap_pct   = (m == 0) ? 15 : (m == 1) ? 72 : 0;
      recv_stall_pct = (m == 0) ? 72 : (m == 1) ? 15 : 0;
      for (int p = 0; p < 3; p++) begin
        drain_results();
        program_offsets(m * 3 + p);
        send_random_sets(RAND_SETS);
      end
    end
    drain_results();

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
